// ===== src/positional_list_insert_delete_core_macros.svh =====
// Assertion macros shared by the positional list core.
// Each macro takes a label, the clock, the active-low reset, the
// antecedent, the consequent and a message string.
`ifndef POSITIONAL_LIST_INSERT_DELETE_CORE_MACROS_SVH
`define POSITIONAL_LIST_INSERT_DELETE_CORE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PLID_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PLID_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/plid_pkg.sv =====
// ----------------------------------------------------------------------------
// plid_pkg: shared types and codes of the positional list core
// Request and status codes, field widths, controller state encoding and the
// command and status groups between the controller and the datapath.
// ----------------------------------------------------------------------------
package plid_pkg;

    // Field widths of the stream items.
    localparam int unsigned REQ_W    = 2;
    localparam int unsigned POS_W    = 5;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned ENTRY_W  = 5;

    // Request codes.
    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_DELETE = 2'd1;
    localparam logic [REQ_W-1:0] REQ_DUMP   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_NONE   = 2'd3;

    // Result status codes.
    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd3;

    // Controller states, one-hot.
    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_SINGLE = 3'b010,
        S_DUMP   = 3'b100
    } t_state;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic exec;   // execute the request on the input side
        logic step;   // load the next dump entry into the output register
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic dump_go;   // presented request is a dump of a non-empty list
        logic last;      // output register holds the final result of a run
    } t_stat;

endpackage

// ===== src/plid_ctrl.sv =====
// ----------------------------------------------------------------------------
// plid_ctrl: request sequencer of the positional list core
// Runs the stream handshakes and tells the datapath when to execute a
// request and when to advance a dump.
// ----------------------------------------------------------------------------
module plid_ctrl (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    output logic            o_out_valid,
    input  logic            i_out_ready,
    input  plid_pkg::t_stat i_stat,
    output plid_pkg::t_cmd  o_cmd
);

    plid_pkg::t_state r_state;
    plid_pkg::t_state n_state;
    logic             in_fire;
    logic             out_fire;

    // A result is pending whenever the sequencer is not idle.
    assign o_out_valid = (r_state != plid_pkg::S_IDLE);

    // A new request enters when idle, or together with the final transfer of a run.
    assign o_in_ready = (r_state == plid_pkg::S_IDLE) || (i_out_ready && i_stat.last);

    assign in_fire  = i_in_valid && o_in_ready;
    assign out_fire = o_out_valid && i_out_ready;

    assign o_cmd.exec = in_fire;
    assign o_cmd.step = out_fire && !i_stat.last;

    // Next-state logic.
    always_comb begin
        n_state = r_state;
        priority if (in_fire) begin
            n_state = i_stat.dump_go ? plid_pkg::S_DUMP : plid_pkg::S_SINGLE;
        end else if (out_fire) begin
            n_state = i_stat.last ? plid_pkg::S_IDLE : plid_pkg::S_DUMP;
        end
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= plid_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

// ===== src/plid_dpath.sv =====
// ----------------------------------------------------------------------------
// plid_dpath: cell row and result register of the positional list core
// Holds the entries in a row of byte cells that shift or rotate all at
// once, the fill count, the dump countdown and the output register.
// ----------------------------------------------------------------------------
module plid_dpath #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic [plid_pkg::REQ_W-1:0]        i_req_type,
    input  logic [plid_pkg::POS_W-1:0]        i_position,
    input  logic [plid_pkg::BYTE_W-1:0]       i_value,
    input  plid_pkg::t_cmd                    i_cmd,
    output plid_pkg::t_stat                   o_stat,
    output logic [plid_pkg::STATUS_W-1:0]     o_status,
    output logic [plid_pkg::BYTE_W-1:0]       o_data,
    output logic [plid_pkg::ENTRY_W-1:0]      o_entries
);

    localparam int unsigned CW = $clog2(CAPACITY + 1);
    localparam int unsigned IW = $clog2(CAPACITY);
    localparam int unsigned PW = (CW > plid_pkg::POS_W) ? CW : plid_pkg::POS_W;

    logic [plid_pkg::BYTE_W-1:0]   r_cell [CAPACITY];
    logic [plid_pkg::BYTE_W-1:0]   n_cell [CAPACITY];
    logic [plid_pkg::BYTE_W-1:0]   ins_cell [CAPACITY];
    logic [plid_pkg::BYTE_W-1:0]   del_cell [CAPACITY];
    logic [plid_pkg::BYTE_W-1:0]   rot_cell [CAPACITY];
    logic [CW-1:0]                 r_cnt;
    logic [CW-1:0]                 n_cnt;
    logic [CW-1:0]                 cnt_m1;
    logic [CW-1:0]                 r_rem;
    logic [CW-1:0]                 n_rem;
    logic [PW-1:0]                 pos_ext;
    logic [PW-1:0]                 cnt_ext;
    logic [PW-1:0]                 ent_ext;
    logic [plid_pkg::STATUS_W-1:0] r_out_status;
    logic [plid_pkg::STATUS_W-1:0] n_out_status;
    logic [plid_pkg::BYTE_W-1:0]   r_out_data;
    logic [plid_pkg::BYTE_W-1:0]   n_out_data;
    logic                          r_out_last;
    logic                          n_out_last;
    logic [plid_pkg::ENTRY_W-1:0]  r_out_entries;
    logic [plid_pkg::ENTRY_W-1:0]  n_out_entries;
    logic                          cnt_zero;
    logic                          cnt_full;

    assign pos_ext  = PW'(i_position);
    assign cnt_ext  = PW'(r_cnt);
    assign cnt_m1   = r_cnt - CW'(1);
    assign cnt_zero = (r_cnt == '0);
    assign cnt_full = (r_cnt == CW'(CAPACITY));

    assign o_stat.dump_go = (i_req_type == plid_pkg::REQ_DUMP) && !cnt_zero;
    assign o_stat.last    = r_out_last;
    assign o_status       = r_out_status;
    assign o_data         = r_out_data;
    assign o_entries      = r_out_entries;

    // Candidate cell rows: insert shifts back, delete closes the gap,
    // rotate moves the first entry behind the last held one.
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            if (PW'(i) == pos_ext) begin
                ins_cell[i] = i_value;
            end else if (i == 0 || PW'(i) < pos_ext) begin
                ins_cell[i] = r_cell[i];
            end else begin
                ins_cell[i] = r_cell[i-1];
            end

            if (i == CAPACITY - 1) begin
                del_cell[i] = r_cell[i];
            end else if (PW'(i) >= pos_ext) begin
                del_cell[i] = r_cell[i+1];
            end else begin
                del_cell[i] = r_cell[i];
            end

            if (CW'(i) == cnt_m1) begin
                rot_cell[i] = r_cell[0];
            end else if (i == CAPACITY - 1) begin
                rot_cell[i] = r_cell[i];
            end else begin
                rot_cell[i] = r_cell[i+1];
            end
        end
    end

    // Request execution and dump stepping.
    always_comb begin
        n_cell       = r_cell;
        n_cnt        = r_cnt;
        n_rem        = r_rem;
        n_out_status = r_out_status;
        n_out_data   = r_out_data;
        n_out_last   = r_out_last;
        if (i_cmd.exec) begin
            n_out_status = plid_pkg::ST_OK;
            n_out_data   = '0;
            n_out_last   = 1'b1;
            unique case (i_req_type)
                plid_pkg::REQ_INSERT: begin
                    if (pos_ext > cnt_ext) begin
                        n_out_status = plid_pkg::ST_BADPOS;
                    end else if (cnt_full) begin
                        n_out_status = plid_pkg::ST_FULL;
                    end else begin
                        n_cell = ins_cell;
                        n_cnt  = r_cnt + CW'(1);
                    end
                end
                plid_pkg::REQ_DELETE: begin
                    if (cnt_zero) begin
                        n_out_status = plid_pkg::ST_EMPTY;
                    end else if (pos_ext >= cnt_ext) begin
                        n_out_status = plid_pkg::ST_BADPOS;
                    end else begin
                        n_out_data = r_cell[pos_ext[IW-1:0]];
                        n_cell     = del_cell;
                        n_cnt      = cnt_m1;
                    end
                end
                plid_pkg::REQ_DUMP: begin
                    if (cnt_zero) begin
                        n_out_status = plid_pkg::ST_EMPTY;
                    end else begin
                        n_out_data = r_cell[0];
                        n_out_last = (r_cnt == CW'(1));
                        n_cell     = rot_cell;
                        n_rem      = cnt_m1;
                    end
                end
                plid_pkg::REQ_NONE: begin
                    n_out_status = plid_pkg::ST_BADPOS;
                end
                default: begin
                    n_out_status = plid_pkg::ST_BADPOS;
                end
            endcase
        end else if (i_cmd.step) begin
            n_out_data = r_cell[0];
            n_out_last = (r_rem == CW'(1));
            n_cell     = rot_cell;
            n_rem      = r_rem - CW'(1);
        end
        ent_ext       = PW'(n_cnt);
        n_out_entries = i_cmd.exec ? ent_ext[plid_pkg::ENTRY_W-1:0] : r_out_entries;
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt      <= '0;
            r_rem      <= '0;
            r_out_last <= 1'b1;
        end else begin
            r_cnt      <= n_cnt;
            r_rem      <= n_rem;
            r_out_last <= n_out_last;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_cell        <= n_cell;
        r_out_status  <= n_out_status;
        r_out_data    <= n_out_data;
        r_out_entries <= n_out_entries;
    end

endmodule

// ===== src/positional_list_insert_delete_core.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core: bounded ordered byte list
// Insert at an index, delete at an index and dump of all entries, served
// over a slave stream of requests and a master stream of results.
// ----------------------------------------------------------------------------
// An insert, a delete, an error or an unused request code gives one result
// in the cycle after the request transfer; the next request is taken in the
// same cycle as that result's transfer, so with a ready consumer the core
// sustains one such request per clock. A dump of N entries gives N results,
// one per clock while the consumer is ready, and the next request enters
// with the transfer of the last one. Those figures come from the cell row,
// which shifts or rotates every entry at once, and from the single output
// register. After reset the list is empty and requests are taken at once.
module positional_list_insert_delete_core #(
    parameter int unsigned CAPACITY = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // position[4:0], value[12:5], zero[15:13]
    input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // data_out[7:0], entries[12:8], zero[15:13]
    output logic [1:0]  m_axis_tuser,   // status[1:0]
    output logic        m_axis_tlast    // last_item
);

    plid_pkg::t_cmd                  cmd;
    plid_pkg::t_stat                 stat;
    logic [plid_pkg::STATUS_W-1:0]   status;
    logic [plid_pkg::BYTE_W-1:0]     data_out;
    logic [plid_pkg::ENTRY_W-1:0]    entries;
    logic                            s_fire;

    assign s_fire = s_axis_tvalid && s_axis_tready;

    // Handshake sequencer.
    plid_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_stat      (stat),
        .o_cmd       (cmd)
    );

    // Cell row and result register.
    plid_dpath #(
        .CAPACITY (CAPACITY)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req_type (s_axis_tuser),
        .i_position (s_axis_tdata[4:0]),
        .i_value    (s_axis_tdata[12:5]),
        .i_cmd      (cmd),
        .o_stat     (stat),
        .o_status   (status),
        .o_data     (data_out),
        .o_entries  (entries)
    );

    // Result packing.
    assign m_axis_tdata = {3'b000, entries, data_out};
    assign m_axis_tuser = status;
    assign m_axis_tlast = stat.last;

    // Checks.
    `include "positional_list_insert_delete_core_macros.svh"

    `PLID_ASSERT_NEXT(a_req_gives_result, i_clk, i_rst_n, s_fire, m_axis_tvalid, "request transfer without a following result")
    `PLID_ASSERT_SAME(a_req_no_overrun, i_clk, i_rst_n, s_fire, (!m_axis_tvalid || (m_axis_tready && m_axis_tlast)), "request taken while a run is still pending")
    `PLID_ASSERT_SAME(a_error_is_last, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser != plid_pkg::ST_OK)), m_axis_tlast, "error result not marked last")
    `PLID_ASSERT_SAME(a_error_no_data, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser != plid_pkg::ST_OK)), (m_axis_tdata[7:0] == 8'd0), "error result carries data")

endmodule

// ===== tb/positional_list_insert_delete_core_tb.sv =====
// ----------------------------------------------------------------------------
// positional_list_insert_delete_core_tb: self-checking bench for the list core
// Sends insert, delete, dump and unused-code requests with random gaps and predicts every
// result from a local copy of the list. Each result transfer is checked field
// by field while the result side stalls at random.
// ----------------------------------------------------------------------------
module positional_list_insert_delete_core_tb;
    import plid_pkg::*;

    localparam int unsigned CAPACITY     = 16;
    localparam int unsigned N_RANDOM     = 392;
    localparam int unsigned CYCLE_LIMIT  = 400000;
    localparam int unsigned DRAIN_CYCLES = 20;

    // One request as it travels on the request stream.
    typedef struct packed {
        logic [REQ_W-1:0]  kind;
        logic [POS_W-1:0]  pos;
        logic [BYTE_W-1:0] val;
    } list_req_t;

    // One result as it travels on the result stream.
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [BYTE_W-1:0]   data;
        logic                last;
        logic [ENTRY_W-1:0]  entries;
    } list_rsp_t;

    logic        i_clk         = 1'b0;
    logic        i_rst_n       = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata  = '0;   // position[4:0], value[12:5], zero[15:13]
    logic [1:0]  s_axis_tuser  = '0;   // req_type[1:0]
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [15:0] m_axis_tdata;         // data_out[7:0], entries[12:8], zero[15:13]
    logic [1:0]  m_axis_tuser;         // status[1:0]
    logic        m_axis_tlast;

    positional_list_insert_delete_core #(
        .CAPACITY(CAPACITY)
    ) dut (
        .i_clk(i_clk),
        .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .m_axis_tuser(m_axis_tuser),
        .m_axis_tlast(m_axis_tlast)
    );

    // Clock and cycle counter.
    always #2 i_clk = ~i_clk;

    int unsigned cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
    end

    // Predicted list contents and the results still owed by the core.
    logic [BYTE_W-1:0]  held_bytes [CAPACITY];
    logic [ENTRY_W-1:0] held_count = '0;
    list_rsp_t          results_due [$];

    // Request queue and bookkeeping.
    list_req_t   pending_reqs [$];
    list_req_t   on_bus;
    int unsigned planned_fill   = 0;
    int unsigned reqs_planned   = 0;
    int unsigned reqs_taken     = 0;
    int unsigned dumps_served   = 0;
    int unsigned peak_fill      = 0;
    int unsigned results_seen   = 0;
    int unsigned mismatch_count = 0;
    int unsigned status_tally [4] = '{0, 0, 0, 0};
    int unsigned req_gap        = 0;
    int unsigned stall_left     = 0;

    // Queues one result, stamped with the fill level after the request.
    function automatic void owe_result(logic [STATUS_W-1:0] status,
                                       logic [BYTE_W-1:0] data, logic last);
        list_rsp_t rsp;
        rsp.status  = status;
        rsp.data    = data;
        rsp.last    = last;
        rsp.entries = held_count;
        results_due.push_back(rsp);
        status_tally[status]++;
    endfunction

    // Applies one accepted request to the predicted list.
    function automatic void apply_request(list_req_t rq);
        int unsigned k;
        case (rq.kind)
            REQ_INSERT: begin
                // The position check comes before the full check.
                if (rq.pos > held_count) begin
                    owe_result(ST_BADPOS, '0, 1'b1);
                end else if (held_count >= CAPACITY) begin
                    owe_result(ST_FULL, '0, 1'b1);
                end else begin
                    for (k = held_count; k > rq.pos; k--) begin
                        held_bytes[k] = held_bytes[k - 1];
                    end
                    held_bytes[rq.pos] = rq.val;
                    held_count++;
                    owe_result(ST_OK, '0, 1'b1);
                end
            end
            REQ_DELETE: begin
                // An empty list is reported ahead of a bad position.
                if (held_count == 0) begin
                    owe_result(ST_EMPTY, '0, 1'b1);
                end else if (rq.pos >= held_count) begin
                    owe_result(ST_BADPOS, '0, 1'b1);
                end else begin
                    logic [BYTE_W-1:0] gone;
                    gone = held_bytes[rq.pos];
                    for (k = rq.pos; k + 1 < held_count; k++) begin
                        held_bytes[k] = held_bytes[k + 1];
                    end
                    held_count--;
                    owe_result(ST_OK, gone, 1'b1);
                end
            end
            REQ_DUMP: begin
                dumps_served++;
                if (held_count == 0) begin
                    owe_result(ST_EMPTY, '0, 1'b1);
                end else begin
                    for (k = 0; k < held_count; k++) begin
                        owe_result(ST_OK, held_bytes[k], (k + 1 == held_count));
                    end
                end
            end
            default: begin
                // The unused request code is refused as a bad position.
                owe_result(ST_BADPOS, '0, 1'b1);
            end
        endcase
        if (held_count > peak_fill) begin
            peak_fill = held_count;
        end
    endfunction

    // Adds a request to the queue and tracks the fill level it will leave.
    function automatic void add_req(logic [REQ_W-1:0] kind, logic [POS_W-1:0] pos,
                                    logic [BYTE_W-1:0] val);
        list_req_t rq;
        rq.kind = kind;
        rq.pos  = pos;
        rq.val  = val;
        pending_reqs.push_back(rq);
        reqs_planned++;
        if (kind == REQ_INSERT && pos <= planned_fill && planned_fill < CAPACITY) begin
            planned_fill++;
        end else if (kind == REQ_DELETE && pos < planned_fill) begin
            planned_fill--;
        end
    endfunction

    // Gap length: mostly none, some short, a few long, and stretches with no gaps at all.
    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (cycle_count % 600 < 150) begin
            return 0;
        end
        if (roll < 55) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(6, 30);
    endfunction

    // Compares one field of a result and reports a mismatch.
    function automatic void check_field(string name, int unsigned want, int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
            mismatch_count++;
        end
    endfunction

    // Request driver: presents queued requests and predicts on each transfer.
    always @(posedge i_clk) begin : req_driver
        logic valid_next;
        valid_next = s_axis_tvalid;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                apply_request(on_bus);
                reqs_taken++;
                valid_next = 1'b0;
            end
            if (!valid_next) begin
                if (req_gap > 0) begin
                    req_gap--;
                end else if (pending_reqs.size() > 0) begin
                    on_bus = pending_reqs.pop_front();
                    s_axis_tdata <= {3'b000, on_bus.val, on_bus.pos};
                    s_axis_tuser <= on_bus.kind;
                    valid_next = 1'b1;
                    req_gap = pick_gap();
                end
            end
        end
        s_axis_tvalid <= valid_next;
    end

    // Result monitor: checks each transfer and stalls the result side at random.
    always @(posedge i_clk) begin : rsp_monitor
        logic      ready_next;
        list_rsp_t want;
        ready_next = m_axis_tready;
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                results_seen++;
                if (results_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual status %0d data %0d",
                             $time, m_axis_tuser, m_axis_tdata[7:0]);
                    mismatch_count++;
                end else begin
                    want = results_due.pop_front();
                    check_field("status", want.status, m_axis_tuser);
                    check_field("data_out", want.data, m_axis_tdata[7:0]);
                    check_field("last_item", want.last, m_axis_tlast);
                    check_field("entries", want.entries, m_axis_tdata[12:8]);
                end
            end
            if (stall_left > 0) begin
                stall_left--;
                ready_next = 1'b0;
            end else if ($urandom_range(0, 99) < 20) begin
                stall_left = pick_gap();
                ready_next = (stall_left == 0);
            end else begin
                ready_next = 1'b1;
            end
        end
        m_axis_tready <= ready_next;
    end

    // Stimulus, end of run and verdict.
    initial begin : stimulus
        int unsigned k;
        int unsigned roll;
        int unsigned bias;
        int unsigned grow_pct;

        // Empty-list cases, a position past the end and the unused code.
        add_req(REQ_DUMP, 5'd0, 8'h00);
        add_req(REQ_DELETE, 5'd0, 8'h00);
        add_req(REQ_INSERT, 5'd1, 8'h5A);
        add_req(REQ_NONE, 5'd31, 8'hAA);

        // Fill to capacity at the front, at the end and in the middle.
        for (k = 0; k < CAPACITY; k++) begin
            add_req(REQ_INSERT, 5'((k % 3 == 0) ? 0 : (k % 3 == 1) ? k : k / 2),
                    (k == 0) ? 8'hFF : (k == 1) ? 8'h00 : 8'($urandom_range(0, 255)));
        end

        // Full list, far positions, a full dump, deletes at the front, the end and the middle, and a dump.
        add_req(REQ_INSERT, 5'd16, 8'h11);
        add_req(REQ_INSERT, 5'd31, 8'h22);
        add_req(REQ_DELETE, 5'd16, 8'h00);
        add_req(REQ_DUMP, 5'd0, 8'h00);
        add_req(REQ_DELETE, 5'd0, 8'h00);
        add_req(REQ_DELETE, 5'd14, 8'h00);
        add_req(REQ_DELETE, 5'd5, 8'h00);
        add_req(REQ_DUMP, 5'd0, 8'h00);

        // Random part: mostly well-formed requests, biased in turn toward
        // growing, shrinking or holding the list, with some noise mixed in.
        bias = 0;
        for (k = 0; k < N_RANDOM; k++) begin
            if (k % 40 == 0) begin
                bias = $urandom_range(0, 2);
            end
            grow_pct = (bias == 0) ? 75 : (bias == 1) ? 25 : 50;
            roll = $urandom_range(0, 99);
            if (roll < 6) begin
                add_req(REQ_NONE, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
            end else if (roll < 14) begin
                if ($urandom_range(0, 1) == 1) begin
                    add_req(REQ_INSERT, 5'($urandom_range(planned_fill + 1, 31)),
                            8'($urandom_range(0, 255)));
                end else begin
                    add_req(REQ_DELETE, 5'($urandom_range(planned_fill, 31)),
                            8'($urandom_range(0, 255)));
                end
            end else if (roll < 24) begin
                add_req(REQ_DUMP, 5'($urandom_range(0, 31)), 8'($urandom_range(0, 255)));
            end else if ($urandom_range(0, 99) < grow_pct) begin
                add_req(REQ_INSERT, 5'($urandom_range(0, planned_fill)),
                        8'($urandom_range(0, 255)));
            end else begin
                add_req(REQ_DELETE,
                        5'((planned_fill == 0) ? 0 : $urandom_range(0, planned_fill - 1)),
                        8'($urandom_range(0, 255)));
            end
        end

        // Reset once, then let the driver and monitor run.
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (reqs_taken < reqs_planned || results_due.size() > 0) begin
            @(posedge i_clk);
        end
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        $display("Ran %0d requests (%0d dumps), checked %0d results, peak fill %0d of %0d.",
                 reqs_taken, dumps_served, results_seen, peak_fill, CAPACITY);
        $display("Status mix: ok %0d, bad position %0d, empty %0d, full %0d.",
                 status_tally[ST_OK], status_tally[ST_BADPOS], status_tally[ST_EMPTY],
                 status_tally[ST_FULL]);
        if (mismatch_count == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

    // Watchdog on the cycle counter.
    initial begin : watchdog
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
        end
        $display("Timeout after %0d cycles, %0d of %0d requests taken, %0d results owed.",
                 cycle_count, reqs_taken, reqs_planned, results_due.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+src
src/plid_pkg.sv
src/plid_ctrl.sv
src/plid_dpath.sv
src/positional_list_insert_delete_core.sv
tb/positional_list_insert_delete_core_tb.sv
